### rtl/kvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the keyed table
// Widths, command and status codes, and the memory port structs.
// ----------------------------------------------------------------------------
package kvt_pkg;

	// table geometry
	localparam int DEPTH        = 64;
	localparam int PAYLOAD_BITS = 64;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);

	// word field widths
	localparam int CMD_W  = 2;
	localparam int KEY_W  = 32;
	localparam int PORT_W = 64;
	localparam int STAT_W = 3;
	localparam int CAP_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EXISTS  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING = 3'd3;
	localparam logic [STAT_W-1:0] STAT_COLLIDE = 3'd4;

	typedef struct packed {
		logic                    rd_en;
		logic [IDX_W-1:0]        rd_addr;
		logic                    wr_en;
		logic [IDX_W-1:0]        wr_addr;
		logic [KEY_W-1:0]        wr_key;
		logic [PAYLOAD_BITS-1:0] wr_pay;
	} mem_req_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] pay;
	} mem_rsp_t;

endpackage
`default_nettype wire

### rtl/kvt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_if: channel interfaces of the keyed table
// Command, response and capacity write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kvt_cmd_if
	import kvt_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [KEY_W-1:0] key;
	logic signed [KEY_W-1:0] new_key;
	logic [PORT_W-1:0]       payload;

	modport source (output valid, command, key, new_key, payload, input ready);
	modport sink   (input valid, command, key, new_key, payload, output ready);
endinterface

interface kvt_rsp_if
	import kvt_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] found_key;
	logic [PORT_W-1:0]       found_payload;
	logic [CAP_W-1:0]        entry_count;

	modport source (output valid, status, found_key, found_payload, entry_count,
		input ready);
	modport sink   (input valid, status, found_key, found_payload, entry_count,
		output ready);
endinterface

interface kvt_cfg_if
	import kvt_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink   (input valid, capacity_limit, output ready);
endinterface
`default_nettype wire

### rtl/kvt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_store: key and payload memories
// One read port with registered data and one write port, separate addresses.
// ----------------------------------------------------------------------------
module kvt_store
	import kvt_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t mem_req,
	output mem_rsp_t      mem_rsp
);

	logic [KEY_W-1:0]        key_mem [DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			key_mem[mem_req.wr_addr] <= mem_req.wr_key;
			pay_mem[mem_req.wr_addr] <= mem_req.wr_pay;
		end
		if (mem_req.rd_en) begin
			mem_rsp.key <= key_mem[mem_req.rd_addr];
			mem_rsp.pay <= pay_mem[mem_req.rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/kvt_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_seq: command sequencer of the keyed table
// Scans the memory with one key compare per cycle, compacts after delete,
// and holds the response word until it is taken.
// ----------------------------------------------------------------------------
module kvt_seq
	import kvt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] cap_eff,
	kvt_cmd_if.sink               cmd,
	kvt_rsp_if.source             rsp,
	output mem_req_t              mem_req,
	input  wire mem_rsp_t         mem_rsp
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CMD_W-1:0]        op_q;
	logic [KEY_W-1:0]        key_q;
	logic [KEY_W-1:0]        new_key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0]        addr_q;
	logic                    rd_pend_q;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    hit_q;
	logic                    nk_hit_q;
	logic [IDX_W-1:0]        pos_q;
	logic [PAYLOAD_BITS-1:0] fpay_q;
	logic [STAT_W-1:0]       status_q;
	logic                    get_ok_q;

	logic more;
	logic k_match;
	logic nk_match;
	logic scan_done;
	logic issue_scan;
	logic issue_shift;
	logic collide;
	logic add_wr;
	logic upd_wr;

	assign more        = addr_q < count_q;
	assign k_match     = rd_pend_q && (mem_rsp.key == key_q);
	assign nk_match    = rd_pend_q && (mem_rsp.key == new_key_q);
	// update scans every live entry, the others stop at the first hit
	assign scan_done   = (hit_q && (op_q != CMD_UPDATE)) || (!rd_pend_q && !more);
	assign issue_scan  = (state_q == S_SCAN) && !scan_done && more;
	assign issue_shift = (state_q == S_SHIFT) && more;
	// keys are unique, so a hit on new_key is a clash unless it is the old key
	assign collide     = nk_hit_q && (new_key_q != key_q);
	assign add_wr      = (state_q == S_SCAN) && scan_done && (op_q == CMD_ADD) && !hit_q;
	assign upd_wr      = (state_q == S_SCAN) && scan_done && (op_q == CMD_UPDATE)
		&& hit_q && !collide;

	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		mem_req.rd_en   = issue_scan || issue_shift;
		mem_req.rd_addr = addr_q[IDX_W-1:0];
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = rd_idx_s1 - IDX_W'(1);
		mem_req.wr_key  = mem_rsp.key;
		mem_req.wr_pay  = mem_rsp.pay;
		priority if (add_wr) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = count_q[IDX_W-1:0];
			mem_req.wr_key  = key_q;
			mem_req.wr_pay  = pay_q;
		end else if (upd_wr) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = pos_q;
			mem_req.wr_key  = new_key_q;
			mem_req.wr_pay  = pay_q;
		end else if ((state_q == S_SHIFT) && rd_pend_q) begin
			// move the entry just read one slot down
			mem_req.wr_en = 1'b1;
		end else begin
			mem_req.wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			count_q           <= '0;
			op_q              <= CMD_ADD;
			key_q             <= '0;
			new_key_q         <= '0;
			pay_q             <= '0;
			addr_q            <= '0;
			rd_pend_q         <= 1'b0;
			rd_idx_s1         <= '0;
			hit_q             <= 1'b0;
			nk_hit_q          <= 1'b0;
			pos_q             <= '0;
			fpay_q            <= '0;
			status_q          <= STAT_OK;
			get_ok_q          <= 1'b0;
			rsp.valid         <= 1'b0;
			rsp.status        <= STAT_OK;
			rsp.found_key     <= '0;
			rsp.found_payload <= '0;
			rsp.entry_count   <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q      <= cmd.command;
						key_q     <= cmd.key;
						new_key_q <= cmd.new_key;
						pay_q     <= cmd.payload[PAYLOAD_BITS-1:0];
						addr_q    <= '0;
						rd_pend_q <= 1'b0;
						hit_q     <= 1'b0;
						nk_hit_q  <= 1'b0;
						get_ok_q  <= 1'b0;
						status_q  <= STAT_OK;
						if ((cmd.command == CMD_ADD) && (count_q >= cap_eff)) begin
							status_q <= STAT_FULL;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_pend_q <= issue_scan;
					if (issue_scan) begin
						rd_idx_s1 <= addr_q[IDX_W-1:0];
						addr_q    <= addr_q + CNT_W'(1);
					end
					if (k_match) begin
						hit_q  <= 1'b1;
						pos_q  <= rd_idx_s1;
						fpay_q <= mem_rsp.pay;
					end
					if (nk_match) begin
						nk_hit_q <= 1'b1;
					end
					if (scan_done) begin
						rd_pend_q <= 1'b0;
						state_q   <= S_DONE;
						unique case (op_q)
							CMD_ADD: begin
								if (hit_q) begin
									status_q <= STAT_EXISTS;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_DELETE: begin
								if (!hit_q) begin
									status_q <= STAT_MISSING;
								end else begin
									addr_q  <= CNT_W'(pos_q) + CNT_W'(1);
									state_q <= S_SHIFT;
								end
							end
							CMD_GET: begin
								if (!hit_q) begin
									status_q <= STAT_MISSING;
								end else begin
									get_ok_q <= 1'b1;
								end
							end
							CMD_UPDATE: begin
								if (!hit_q) begin
									status_q <= STAT_MISSING;
								end else if (collide) begin
									status_q <= STAT_COLLIDE;
								end
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				S_SHIFT: begin
					rd_pend_q <= issue_shift;
					if (issue_shift) begin
						rd_idx_s1 <= addr_q[IDX_W-1:0];
						addr_q    <= addr_q + CNT_W'(1);
					end
					if (!rd_pend_q && !more) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid         <= 1'b1;
						rsp.status        <= status_q;
						rsp.found_key     <= get_ok_q ? key_q : '0;
						rsp.found_payload <= get_ok_q ? PORT_W'(fpay_q) : '0;
						rsp.entry_count   <= CAP_W'(count_q);
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/keyed_table_with_compaction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_table_with_compaction: packed, insertion-ordered key/payload table
// Add, delete, get and update by 32-bit key; delete compacts the table.
// ----------------------------------------------------------------------------
// Operation: one command at a time. Get and a duplicate add stop the search
//   at the hit, update searches every live entry, and an add to a full table
//   answers without a search; delete stops the search at the hit, and the move
//   down covers only the later entries.
// Flow: the next command is taken in the cycle after the response is loaded;
//   a response that is not taken holds the next one in its last state.
// Reset: arst_n clears the live count and sets the capacity to 64. Memory
//   contents are not cleared; only live entries are ever read.
// ----------------------------------------------------------------------------
module keyed_table_with_compaction
	import kvt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	kvt_cmd_if.sink   cmd,
	kvt_rsp_if.source rsp,
	kvt_cfg_if.sink   cfg
);

	// Capacity register. The write channel never stalls; software must change
	// it only while no command is in flight, which the block does not enforce.
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity_limit;
		end
	end

	// Clip the limit to the built depth.
	always_comb begin
		if (32'(cap_q) >= DEPTH) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	// Memory port between the sequencer and the storage.
	mem_req_t mem_req;
	mem_rsp_t mem_rsp;

	// Sequencer: one key compare per cycle against the word read from the
	// memory, then a one-entry-per-cycle move down for delete. It holds the
	// finished response word in its output register until it is taken.
	kvt_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap_eff (cap_eff),
		.cmd     (cmd),
		.rsp     (rsp),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

	// Key and payload storage, one read and one write per cycle.
	kvt_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

endmodule
`default_nettype wire
